### src/prq_pkg.sv
// ----------------------------------------------------------------------------
// Priority ready queue package
// Shared types and codes for the ready queue core, its cells and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prq_pkg;

  localparam int ID_W     = 6;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int FPRIO_W  = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_UPD = 2'd1,
    CMD_DEQ = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_DUP    = 3'd3,
    STAT_ABSENT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT
  } state_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] tid;
  } cell_ctl_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [ID_W-1:0]    task_id;
    logic [FPRIO_W-1:0] task_priority;
  } cmd_beat_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    out_id;
    logic [COUNT_W-1:0] queued_count;
  } rsp_beat_t;

endpackage

### src/priority_ready_queue_core.sv
// ----------------------------------------------------------------------------
// Priority ready queue core
// Sorted ready queue of task ids built as a row of cells, highest priority
// in cell 0, first come first served among equal priorities.
//
//   channel   direction  handshake            beat
//   cmd       in         cmd_valid/cmd_stall  cmd_beat_t (cmd, id, priority)
//   rsp       out        rsp_valid/rsp_stall  rsp_beat_t (status, id, count)
//   cfg       in         cfg_wr_en            idle id, 6 bits
//
// Enqueue, dequeue, a rejected command and an update of an absent id each
// finish in the idle state. An update of a queued id takes a lookup, a
// shift that closes the gap, and an insert, all through the one cell row.
// Synchronous reset clears the fill and result counts, the idle id and the
// sequencer; slot contents are not reset, only read below the fill count.
// A two-entry result buffer lets the next command beat be taken while a
// finished result beat is still stalled; commands stall only when both
// entries are held or an update is in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_ready_queue_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int PRIO_BITS   = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  prq_pkg::cmd_beat_t     cmd_data,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output prq_pkg::rsp_beat_t     rsp_data,
  input  logic                   cfg_wr_en,
  input  logic [prq_pkg::ID_W-1:0] cfg_wr_data
);
  import prq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W = $clog2(QUEUE_DEPTH);

  // Control registers.
  state_t             state, state_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [ID_W-1:0]    idle_id;

  // Update in flight: where the task sits, and what goes back in.
  logic [POS_W-1:0]     upd_pos;
  logic [ID_W-1:0]      upd_tid;
  logic [PRIO_BITS-1:0] upd_prio;

  // Two-entry result buffer; entry 0 is what the rsp channel shows.
  rsp_beat_t  rbuf0, rbuf1;
  logic [1:0] rcount;

  // Cell row.
  logic [ID_W-1:0]      cell_tid  [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ge;
  logic [QUEUE_DEPTH-1:0] cell_hit;
  logic [QUEUE_DEPTH-1:0] cell_occ;
  logic [QUEUE_DEPTH-1:0] cell_shift;

  cell_ctl_t            ctl;
  logic [PRIO_BITS-1:0] ctl_prio;
  logic                 shift_all;

  logic                 accept;
  logic                 found;
  logic [POS_W-1:0]     hit_pos;
  logic                 q_full;
  logic                 q_empty;
  logic [PRIO_BITS-1:0] in_prio;
  logic                 push;
  rsp_beat_t            push_beat;
  logic                 pop;
  logic                 upd_load;

  assign cmd_stall = (state != S_IDLE) || (rcount == 2'd2);
  assign accept    = cmd_valid && !cmd_stall;
  assign in_prio   = PRIO_BITS'(cmd_data.task_priority);
  assign q_full    = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_empty   = (fill == '0);
  assign found     = |cell_hit;

  // Binary position of the matching cell; at most one cell can match.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cell_hit[i]) begin
        hit_pos = hit_pos | POS_W'(i);
      end
    end
  end

  // Occupancy and shift selection for each cell come from its fixed place.
  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                 l_ge;
      logic [ID_W-1:0]      l_tid;
      logic [PRIO_BITS-1:0] l_prio;
      logic [ID_W-1:0]      r_tid;
      logic [PRIO_BITS-1:0] r_prio;

      assign cell_occ[g]   = CNT_W'(g) < fill;
      assign cell_shift[g] = shift_all || (POS_W'(g) >= upd_pos);

      if (g == 0) begin : g_head
        assign l_ge   = 1'b1;
        assign l_tid  = '0;
        assign l_prio = '0;
      end else begin : g_body
        assign l_ge   = cell_ge[g-1];
        assign l_tid  = cell_tid[g-1];
        assign l_prio = cell_prio[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign r_tid  = '0;
        assign r_prio = '0;
      end else begin : g_inner
        assign r_tid  = cell_tid[g+1];
        assign r_prio = cell_prio[g+1];
      end

      prq_cell #(
        .PRIO_BITS(PRIO_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_prio  (ctl_prio),
        .occ       (cell_occ[g]),
        .left_ge   (l_ge),
        .left_tid  (l_tid),
        .left_prio (l_prio),
        .right_tid (r_tid),
        .right_prio(r_prio),
        .shift_sel (cell_shift[g]),
        .tid       (cell_tid[g]),
        .prio      (cell_prio[g]),
        .ge        (cell_ge[g]),
        .hit       (cell_hit[g])
      );
    end
  endgenerate

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (cmd_data.cmd == CMD_UPD) && found) begin
          state_next = S_REMOVE;
        end
      end
      S_REMOVE: state_next = S_INSERT;
      S_INSERT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: cell row operation, count change and result beat.
  always_comb begin
    ctl.op       = CELL_HOLD;
    ctl.tid      = cmd_data.task_id;
    ctl_prio     = in_prio;
    shift_all    = 1'b0;
    fill_next    = fill;
    push         = 1'b0;
    upd_load     = 1'b0;
    push_beat    = '{status: STAT_OK, out_id: '0, queued_count: '0};
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_data.cmd)
            CMD_ENQ: begin
              push = 1'b1;
              if (found) begin
                push_beat.status = STAT_DUP;
              end else if (q_full) begin
                push_beat.status = STAT_FULL;
              end else begin
                ctl.op    = CELL_INSERT;
                fill_next = fill + 1'b1;
              end
            end
            CMD_UPD: begin
              if (found) begin
                upd_load = 1'b1;
              end else begin
                push             = 1'b1;
                push_beat.status = STAT_ABSENT;
              end
            end
            CMD_DEQ: begin
              push = 1'b1;
              if (q_empty) begin
                push_beat.status = STAT_EMPTY;
                push_beat.out_id = idle_id;
              end else begin
                push_beat.out_id = cell_tid[0];
                ctl.op           = CELL_SHIFT;
                shift_all        = 1'b1;
                fill_next        = fill - 1'b1;
              end
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      S_REMOVE: begin
        // Close the gap at the updated task's slot.
        ctl.op    = CELL_SHIFT;
        fill_next = fill - 1'b1;
      end
      S_INSERT: begin
        ctl.op    = CELL_INSERT;
        ctl.tid   = upd_tid;
        ctl_prio  = upd_prio;
        fill_next = fill + 1'b1;
        push      = 1'b1;
      end
      default: begin
      end
    endcase
    push_beat.queued_count = COUNT_W'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      idle_id <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_wr_en) begin
        idle_id <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_load) begin
      upd_pos  <= hit_pos;
      upd_tid  <= cmd_data.task_id;
      upd_prio <= in_prio;
    end
  end

  // Result buffer. A push always finds room: commands are taken only when
  // an entry is free, and an update pushes once at its end.
  assign rsp_valid = (rcount != 2'd0);
  assign rsp_data  = rbuf0;
  assign pop       = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rcount <= 2'd0;
    end else begin
      rcount <= rcount + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (rcount == 2'd1)) begin
        rbuf0 <= push_beat;
      end else begin
        rbuf0 <= rbuf1;
        if (push) begin
          rbuf1 <= push_beat;
        end
      end
    end else if (push) begin
      if (rcount == 2'd0) begin
        rbuf0 <= push_beat;
      end else begin
        rbuf1 <= push_beat;
      end
    end
  end

endmodule

### src/prq_cell.sv
// ----------------------------------------------------------------------------
// Priority ready queue cell
// One slot of the sorted row: holds a task id and its priority and trades
// them with its neighbors on insert and shift operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prq_cell #(
  parameter int PRIO_BITS = 6
) (
  input  logic                    clk,
  input  prq_pkg::cell_ctl_t      ctl,
  input  logic [PRIO_BITS-1:0]    new_prio,
  input  logic                    occ,
  input  logic                    left_ge,
  input  logic [prq_pkg::ID_W-1:0] left_tid,
  input  logic [PRIO_BITS-1:0]    left_prio,
  input  logic [prq_pkg::ID_W-1:0] right_tid,
  input  logic [PRIO_BITS-1:0]    right_prio,
  input  logic                    shift_sel,
  output logic [prq_pkg::ID_W-1:0] tid,
  output logic [PRIO_BITS-1:0]    prio,
  output logic                    ge,
  output logic                    hit
);
  import prq_pkg::*;

  // A slot ranks ahead of a newcomer when its priority is at least as high.
  assign ge  = occ && (prio >= new_prio);
  assign hit = occ && (tid == ctl.tid);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (!ge) begin
          if (left_ge) begin
            tid  <= ctl.tid;
            prio <= new_prio;
          end else begin
            tid  <= left_tid;
            prio <= left_prio;
          end
        end
      end
      CELL_SHIFT: begin
        if (shift_sel) begin
          tid  <= right_tid;
          prio <= right_prio;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/prq_checker.sv
// ----------------------------------------------------------------------------
// Priority ready queue checker
// Port-level properties of the ready queue core, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prq_props #(
  parameter int QUEUE_DEPTH = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input prq_pkg::rsp_beat_t rsp_data
);
  import prq_pkg::*;

  // An empty queue can only report a count of zero.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == STAT_EMPTY) |-> rsp_data.queued_count == '0)
    else $error("empty status with a nonzero count");

  // A dropped enqueue means the queue was at its full depth.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == STAT_FULL)
      |-> rsp_data.queued_count == COUNT_W'(QUEUE_DEPTH))
    else $error("full status below full depth");

  // Rejected commands carry no id.
  a_reject_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((rsp_data.status == STAT_FULL) || (rsp_data.status == STAT_DUP) ||
                  (rsp_data.status == STAT_ABSENT)) |-> rsp_data.out_id == '0)
    else $error("rejected command returned an id");

  // A stalled result beat stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result beat changed");

endmodule

bind priority_ready_queue_core prq_props #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_prq_props (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp_data (rsp_data)
);
